// ===== hdl/tcpp_pkg.sv =====
`default_nettype none
package tcpp_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int LEN_FRAC   = 8;
    localparam int ID_BITS    = 16;
    localparam int SIZE_BITS  = 13;
    localparam int VAL_BITS   = 17;
    localparam int CNT_BITS   = 4;
    localparam int ACT_BITS   = 3;
    localparam int LANES      = 3;
    localparam int MIN_CONTACTS = 3;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int QA_BITS   = COORD_BITS + 3;
    localparam int NUM_BITS  = COORD_BITS + QA_BITS + 2;
    localparam int NX_BITS   = NUM_BITS + QA_BITS + 1;
    localparam int NY_BITS   = NUM_BITS + DIFF_BITS + 1;
    localparam int DEN_BITS  = NUM_BITS + 3;
    localparam int QW        = NX_BITS;
    localparam int DIV_CNT_BITS = $clog2(QW + 1);

    localparam int CEN_BITS  = COORD_BITS + 6;
    localparam int CEN_LIM   = 2 ** (COORD_BITS + 4);
    localparam int DXC_BITS  = CEN_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS + 11;
    localparam int LEN_BITS  = (SQ_BITS + 2 * LEN_FRAC + 1) / 2;
    localparam int RAD_BITS  = 2 * LEN_BITS;
    localparam int WHOLE_BITS = LEN_BITS - LEN_FRAC;
    localparam int ROOT_CNT_BITS = $clog2(LEN_BITS);

    localparam int SCALE_BITS = 17 + FRAC_BITS;
    localparam int PROD_BITS  = SCALE_BITS + SIZE_BITS;
    localparam int MAG_BITS   = VAL_BITS - 1;

    localparam int IN_BITS  = CNT_BITS + LANES * (ID_BITS + 2 * COORD_BITS) + 2 * COORD_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * VAL_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_NONE   = 3'd0,
        ACT_NAV    = 3'd1,
        ACT_PINCH  = 3'd2,
        ACT_MOVE   = 3'd3,
        ACT_RESIZE = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NAV   = 2'd1,
        MODE_PINCH = 2'd2
    } mode_t;

    typedef struct packed {
        logic [IN_W-IN_BITS-1:0] pad;
        logic [COORD_BITS-1:0]   third_y;
        logic [COORD_BITS-1:0]   third_x;
        logic [ID_BITS-1:0]      third_id;
        logic [COORD_BITS-1:0]   second_y;
        logic [COORD_BITS-1:0]   second_x;
        logic [ID_BITS-1:0]      second_id;
        logic [COORD_BITS-1:0]   first_surface_y;
        logic [COORD_BITS-1:0]   first_surface_x;
        logic [COORD_BITS-1:0]   first_y;
        logic [COORD_BITS-1:0]   first_x;
        logic [ID_BITS-1:0]      first_id;
        logic [CNT_BITS-1:0]     contact_count;
    } in_frame_t;

    typedef struct packed {
        logic [OUT_W-OUT_BITS-1:0]  pad;
        logic signed [VAL_BITS-1:0] value_b;
        logic signed [VAL_BITS-1:0] value_a;
    } out_data_t;

    typedef struct packed {
        logic [SQ_BITS-1:0]  sq;
        logic [LEN_BITS-1:0] len;
    } lane_res_t;

    function automatic logic signed [DIFF_BITS-1:0] to_s(input logic [COORD_BITS-1:0] v);
        return $signed({1'b0, v});
    endfunction

    function automatic logic signed [CEN_BITS-1:0] centre_of(
        input logic [QW-1:0] quo,
        input logic          neg,
        input logic          num_zero,
        input logic          den_zero
    );
        logic [CEN_BITS-1:0] mag;
        if (den_zero) begin
            mag = num_zero ? '0 : CEN_BITS'(CEN_LIM);
        end else if (quo > QW'(CEN_LIM)) begin
            mag = CEN_BITS'(CEN_LIM);
        end else begin
            mag = quo[CEN_BITS-1:0];
        end
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [VAL_BITS-1:0] size_of(
        input logic [PROD_BITS-1:0] prod,
        input logic                 sat,
        input logic [SIZE_BITS-1:0] base
    );
        logic [MAG_BITS-1:0] mag;
        if (base == '0) begin
            mag = '0;
        end else if (sat || (prod[PROD_BITS-1:FRAC_BITS+MAG_BITS] != '0)) begin
            mag = '1;
        end else begin
            mag = prod[FRAC_BITS+MAG_BITS-1:FRAC_BITS];
        end
        return $signed({1'b0, mag});
    endfunction

endpackage
`default_nettype wire

// ===== hdl/three_contact_pan_pinch_recognizer_top.sv =====
`default_nettype none
// Three-contact pan and pinch recognizer. One touch frame is taken per request and exactly
// one result is returned for it. A frame with fewer than three contacts, like a navigation
// frame, uses neither the divider nor the lanes. The first frame of a gesture runs the
// median pipeline, two signed divisions on the shared radix-2 divider, and the three
// distance lanes, whose bit-pair square root sets their length. A pinch frame runs the
// lanes and, when the reference contact's length has changed, the scale division (not for
// a zero length) and the size multiply. One frame is in work at a time; a finished result
// waits in the output register while the next frame is already taken.
module three_contact_pan_pinch_recognizer_top import tcpp_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // contact_count, first_id, first_x, first_y, first_surface_x, first_surface_y,
    // second_id, second_x, second_y, third_id, third_x, third_y, zero fill
    input  logic [IN_W-1:0]         s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // value_a, value_b, zero fill
    output logic [OUT_W-1:0]        m_tdata,
    // action
    output logic [ACT_BITS-1:0]     m_tuser,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]    cfg_data
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_MED   = 11'b00000000010,
        ST_DIVX  = 11'b00000000100,
        ST_DIVY  = 11'b00000001000,
        ST_LANE  = 11'b00000010000,
        ST_NAV   = 11'b00000100000,
        ST_PLANE = 11'b00001000000,
        ST_SCALE = 11'b00010000000,
        ST_MULT  = 11'b00100000000,
        ST_SIZE  = 11'b01000000000,
        ST_EMIT  = 11'b10000000000
    } state_t;

    in_frame_t frm;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   kick_reg, kick_next;
    logic   mval_reg, mval_next;
    logic   sat_reg, sat_next;

    logic [SIZE_BITS-1:0]  pw_reg, ph_reg, bw_reg, bw_next, bh_reg, bh_next;
    logic [ID_BITS-1:0]    fid_reg [LANES];
    logic [COORD_BITS-1:0] fx_reg [LANES];
    logic [COORD_BITS-1:0] fy_reg [LANES];
    logic [ID_BITS-1:0]    ref_id_reg, ref_id_next;
    logic [COORD_BITS-1:0] ref_x_reg, ref_x_next, ref_y_reg, ref_y_next;
    logic [COORD_BITS-1:0] ssx_reg, ssx_next, ssy_reg, ssy_next;
    logic signed [DIFF_BITS-1:0] lox_reg, lox_next, loy_reg, loy_next;
    logic [WHOLE_BITS-1:0] lw_reg, lw_next;
    logic signed [CEN_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [LEN_BITS-1:0]   lr_reg, lr_next, ln_reg, ln_next;
    logic [SCALE_BITS-1:0] scale_reg, scale_next;
    logic [PROD_BITS-1:0]  prw_reg, prh_reg;
    logic [ACT_BITS-1:0]   ract_reg, ract_next, mact_reg;
    logic signed [VAL_BITS-1:0] ra_reg, ra_next, rb_reg, rb_next, ma_reg, mb_reg;

    logic med_done, div_start, div_done;
    logic signed [NX_BITS-1:0]  numx;
    logic signed [NY_BITS-1:0]  numy;
    logic signed [DEN_BITS-1:0] denx, deny;
    logic [QW-1:0]       div_num, quo;
    logic [DEN_BITS-1:0] div_den;
    logic [LANES-1:0]    lane_done;
    lane_res_t           lres [LANES];
    logic                accept, out_free;
    out_data_t           mdat;

    assign frm       = in_frame_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !mval_reg || m_tready;
    assign cfg_ready = 1'b1;

    tcpp_median u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (kick_reg && (state_reg == ST_MED)),
        .x0      (fx_reg[0]),
        .y0      (fy_reg[0]),
        .x1      (fx_reg[1]),
        .y1      (fy_reg[1]),
        .x2      (fx_reg[2]),
        .y2      (fy_reg[2]),
        .done    (med_done),
        .num_x   (numx),
        .den_x   (denx),
        .num_y   (numy),
        .den_y   (deny)
    );

    always_comb begin
        div_start = kick_reg && ((state_reg == ST_DIVX) || (state_reg == ST_DIVY)
                                 || (state_reg == ST_SCALE));
        case (state_reg)
            ST_DIVX: begin
                div_num = numx[NX_BITS-1] ? QW'(-numx) : QW'(numx);
                div_den = denx[DEN_BITS-1] ? DEN_BITS'(-denx) : DEN_BITS'(denx);
            end
            ST_DIVY: begin
                div_num = numy[NY_BITS-1] ? QW'(-numy) : QW'(numy);
                div_den = deny[DEN_BITS-1] ? DEN_BITS'(-deny) : DEN_BITS'(deny);
            end
            default: begin
                div_num = QW'({lr_reg, {FRAC_BITS{1'b0}}});
                div_den = DEN_BITS'(ln_reg);
            end
        endcase
    end

    tcpp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (quo)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        tcpp_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (kick_reg && ((state_reg == ST_LANE) || (state_reg == ST_PLANE))),
            .px      (fx_reg[g]),
            .py      (fy_reg[g]),
            .cx      (cx_reg),
            .cy      (cy_reg),
            .done    (lane_done[g]),
            .res     (lres[g])
        );
    end

    always_comb begin
        logic                        found, pinch;
        logic signed [DIFF_BITS-1:0] dxk, dyk, selx, sely;
        logic [WHOLE_BITS-1:0]       wk, selw;
        logic [LEN_BITS-1:0]         sell;
        logic [SQ_BITS-1:0]          mx;

        state_next = state_reg;
        mode_next  = mode_reg;
        kick_next  = 1'b0;
        sat_next   = sat_reg;
        bw_next = bw_reg;   bh_next = bh_reg;
        ref_id_next = ref_id_reg;
        ref_x_next = ref_x_reg; ref_y_next = ref_y_reg;
        ssx_next = ssx_reg;     ssy_next = ssy_reg;
        lox_next = lox_reg;     loy_next = loy_reg;
        lw_next = lw_reg;
        cx_next = cx_reg;       cy_next = cy_reg;
        lr_next = lr_reg;       ln_next = ln_reg;
        scale_next = scale_reg;
        ract_next = ract_reg;   ra_next = ra_reg;   rb_next = rb_reg;
        found = 1'b0; pinch = 1'b1;
        dxk = '0; dyk = '0; selx = '0; sely = '0;
        wk = '0; selw = '0; sell = '0; mx = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ract_next = ACT_NONE;
                    ra_next = '0;
                    rb_next = '0;
                    if (frm.contact_count < CNT_BITS'(MIN_CONTACTS)) begin
                        mode_next  = MODE_IDLE;
                        state_next = ST_EMIT;
                    end else begin
                        case (mode_reg)
                            MODE_IDLE: begin
                                ref_id_next = frm.first_id;
                                ref_x_next  = frm.first_x;
                                ref_y_next  = frm.first_y;
                                ssx_next    = frm.first_surface_x;
                                ssy_next    = frm.first_surface_y;
                                lox_next    = '0;
                                loy_next    = '0;
                                lw_next     = '0;
                                kick_next   = 1'b1;
                                state_next  = ST_MED;
                            end
                            MODE_NAV: state_next = ST_NAV;
                            MODE_PINCH: begin
                                kick_next  = 1'b1;
                                state_next = ST_PLANE;
                            end
                            default: state_next = ST_EMIT;
                        endcase
                    end
                end
            end
            ST_MED: begin
                if (med_done) begin
                    kick_next  = 1'b1;
                    state_next = ST_DIVX;
                end
            end
            ST_DIVX: begin
                if (div_done) begin
                    cx_next = centre_of(quo, (denx == '0) ? numx[NX_BITS-1]
                                        : (numx[NX_BITS-1] ^ denx[DEN_BITS-1]),
                                        numx == '0, denx == '0);
                    kick_next  = 1'b1;
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY: begin
                if (div_done) begin
                    cy_next = centre_of(quo, (deny == '0) ? numy[NY_BITS-1]
                                        : (numy[NY_BITS-1] ^ deny[DEN_BITS-1]),
                                        numy == '0, deny == '0);
                    kick_next  = 1'b1;
                    state_next = ST_LANE;
                end
            end
            ST_LANE: begin
                if (lane_done[0]) begin
                    mx = lres[0].sq;
                    for (int k = 1; k < LANES; k++) begin
                        if (lres[k].sq > mx) begin
                            mx = lres[k].sq;
                        end
                    end
                    for (int k = 0; k < LANES; k++) begin
                        if (!({lres[k].sq, 2'b00} > {2'b00, mx})) begin
                            pinch = 1'b0;
                        end
                    end
                    lr_next = lres[0].len;
                    if (pinch) begin
                        mode_next = MODE_PINCH;
                        ract_next = ACT_PINCH;
                        bw_next   = pw_reg;
                        bh_next   = ph_reg;
                    end else begin
                        mode_next = MODE_NAV;
                        ract_next = ACT_NAV;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_NAV: begin
                for (int k = 0; k < LANES; k++) begin
                    dxk = to_s(fx_reg[k]) - to_s(ref_x_reg);
                    dyk = to_s(fy_reg[k]) - to_s(ref_y_reg);
                    if (!found && (fid_reg[k] == ref_id_reg)
                        && ((dxk != lox_reg) || (dyk != loy_reg))) begin
                        found = 1'b1;
                        selx = dxk;
                        sely = dyk;
                    end
                end
                if (found) begin
                    lox_next  = selx;
                    loy_next  = sely;
                    ract_next = ACT_MOVE;
                    ra_next = VAL_BITS'(to_s(ssx_reg)) - VAL_BITS'(selx);
                    rb_next = VAL_BITS'(to_s(ssy_reg)) - VAL_BITS'(sely);
                end
                state_next = ST_EMIT;
            end
            ST_PLANE: begin
                if (lane_done[0]) begin
                    for (int k = 0; k < LANES; k++) begin
                        wk = lres[k].len[LEN_BITS-1:LEN_FRAC];
                        if (!found && (fid_reg[k] == ref_id_reg) && (wk != lw_reg)) begin
                            found = 1'b1;
                            selw = wk;
                            sell = lres[k].len;
                        end
                    end
                    if (!found) begin
                        state_next = ST_EMIT;
                    end else begin
                        lw_next = selw;
                        ln_next = sell;
                        if (sell == '0) begin
                            sat_next   = 1'b1;
                            scale_next = '0;
                            state_next = ST_MULT;
                        end else begin
                            kick_next  = 1'b1;
                            state_next = ST_SCALE;
                        end
                    end
                end
            end
            ST_SCALE: begin
                if (div_done) begin
                    sat_next   = (quo[QW-1:SCALE_BITS] != '0);
                    scale_next = quo[SCALE_BITS-1:0];
                    state_next = ST_MULT;
                end
            end
            ST_MULT: state_next = ST_SIZE;
            ST_SIZE: begin
                ract_next  = ACT_RESIZE;
                ra_next    = size_of(prw_reg, sat_reg, bw_reg);
                rb_next    = size_of(prh_reg, sat_reg, bh_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign mval_next = ((state_reg == ST_EMIT) && out_free) || (mval_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_IDLE;
            kick_reg   <= 1'b0;
            mval_reg   <= 1'b0;
            pw_reg     <= '0;
            ph_reg     <= '0;
            bw_reg     <= '0;
            bh_reg     <= '0;
            ref_id_reg <= '0;
            ref_x_reg  <= '0;
            ref_y_reg  <= '0;
            ssx_reg    <= '0;
            ssy_reg    <= '0;
            lox_reg    <= '0;
            loy_reg    <= '0;
            lw_reg     <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            lr_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            kick_reg   <= kick_next;
            mval_reg   <= mval_next;
            bw_reg     <= bw_next;
            bh_reg     <= bh_next;
            ref_id_reg <= ref_id_next;
            ref_x_reg  <= ref_x_next;
            ref_y_reg  <= ref_y_next;
            ssx_reg    <= ssx_next;
            ssy_reg    <= ssy_next;
            lox_reg    <= lox_next;
            loy_reg    <= loy_next;
            lw_reg     <= lw_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            lr_reg     <= lr_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_WIDTH) begin
                    pw_reg <= cfg_data;
                end else if (cfg_index == REG_HEIGHT) begin
                    ph_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        sat_reg   <= sat_next;
        ln_reg    <= ln_next;
        scale_reg <= scale_next;
        ract_reg  <= ract_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        prw_reg   <= PROD_BITS'(scale_reg) * PROD_BITS'(bw_reg);
        prh_reg   <= PROD_BITS'(scale_reg) * PROD_BITS'(bh_reg);
        if (accept) begin
            fid_reg[0] <= frm.first_id;
            fid_reg[1] <= frm.second_id;
            fid_reg[2] <= frm.third_id;
            fx_reg[0]  <= frm.first_x;
            fx_reg[1]  <= frm.second_x;
            fx_reg[2]  <= frm.third_x;
            fy_reg[0]  <= frm.first_y;
            fy_reg[1]  <= frm.second_y;
            fy_reg[2]  <= frm.third_y;
        end
        if ((state_reg == ST_EMIT) && out_free) begin
            mact_reg <= ract_reg;
            ma_reg   <= ra_reg;
            mb_reg   <= rb_reg;
        end
    end

    always_comb begin
        mdat.pad     = '0;
        mdat.value_a = ma_reg;
        mdat.value_b = mb_reg;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdat;
    assign m_tuser  = mact_reg;

`ifndef NO_ASSERTIONS
    a_lanes_together: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_done[0] |-> (lane_done == '1))
        else $error("distance lanes finished out of step");

    a_move_in_nav: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && (ract_reg == ACT_MOVE)) |-> (mode_reg == MODE_NAV))
        else $error("move result outside navigation");

    a_pinch_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && (ract_reg == ACT_PINCH || ract_reg == ACT_RESIZE))
        |-> (mode_reg == MODE_PINCH))
        else $error("pinch result without pinch mode");
`endif

endmodule
`default_nettype wire

// ===== hdl/tcpp_median.sv =====
`default_nettype none
module tcpp_median import tcpp_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [COORD_BITS-1:0]       x0,
    input  logic [COORD_BITS-1:0]       y0,
    input  logic [COORD_BITS-1:0]       x1,
    input  logic [COORD_BITS-1:0]       y1,
    input  logic [COORD_BITS-1:0]       x2,
    input  logic [COORD_BITS-1:0]       y2,
    output logic                        done,
    output logic signed [NX_BITS-1:0]   num_x,
    output logic signed [DEN_BITS-1:0]  den_x,
    output logic signed [NY_BITS-1:0]   num_y,
    output logic signed [DEN_BITS-1:0]  den_y
);

    logic [4:0] v_reg;

    logic [COORD_BITS-1:0] m12x_reg, m12y_reg, m23x_reg, m23y_reg;
    logic signed [QA_BITS-1:0]   a1_reg, a2_reg;
    logic signed [DIFF_BITS-1:0] s1_reg, s2_reg;
    logic signed [NUM_BITS-1:0]  p1_reg, p2_reg, p3_reg, p4_reg, d1_reg, d2_reg;
    logic signed [NUM_BITS-1:0]  n1_reg, n2_reg, d_reg;
    logic signed [NX_BITS-1:0]   ax_reg, bx_reg;
    logic signed [NY_BITS-1:0]   cy_reg, dy_reg;
    logic signed [DEN_BITS-1:0]  dd_reg;
    logic signed [NX_BITS-1:0]   numx_reg;
    logic signed [NY_BITS-1:0]   numy_reg;
    logic signed [DEN_BITS-1:0]  denx_reg, deny_reg;

    logic [COORD_BITS:0]         sum12x, sum12y, sum23x, sum23y;
    logic [COORD_BITS-1:0]       m12x, m12y, m23x, m23y;
    logic signed [DIFF_BITS-1:0] c1, c2;

    always_comb begin
        sum12x = {1'b0, x0} + {1'b0, x1};
        sum12y = {1'b0, y0} + {1'b0, y1};
        sum23x = {1'b0, x2} + {1'b0, x1};
        sum23y = {1'b0, y2} + {1'b0, y1};
        m12x = sum12x[COORD_BITS:1];
        m12y = sum12y[COORD_BITS:1];
        m23x = sum23x[COORD_BITS:1];
        m23y = sum23y[COORD_BITS:1];
        c1 = to_s(x2) - to_s(m12x);
        c2 = to_s(x0) - to_s(m23x);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[3:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        m12x_reg <= m12x;
        m12y_reg <= m12y;
        m23x_reg <= m23x;
        m23y_reg <= m23y;
        a1_reg <= (c1 != '0) ? (QA_BITS'(c1) <<< 2) : QA_BITS'(1);
        a2_reg <= (c2 != '0) ? (QA_BITS'(c2) <<< 2) : QA_BITS'(1);
        s1_reg <= to_s(y2) - to_s(m12y);
        s2_reg <= to_s(y0) - to_s(m23y);

        p1_reg <= NUM_BITS'(to_s(m12y_reg)) * NUM_BITS'(a1_reg);
        p2_reg <= NUM_BITS'(s1_reg) * NUM_BITS'(to_s(m12x_reg));
        p3_reg <= NUM_BITS'(to_s(m23y_reg)) * NUM_BITS'(a2_reg);
        p4_reg <= NUM_BITS'(s2_reg) * NUM_BITS'(to_s(m23x_reg));
        d1_reg <= NUM_BITS'(s1_reg) * NUM_BITS'(a2_reg);
        d2_reg <= NUM_BITS'(s2_reg) * NUM_BITS'(a1_reg);

        n1_reg <= p1_reg - (p2_reg <<< 2);
        n2_reg <= p3_reg - (p4_reg <<< 2);
        d_reg  <= d1_reg - d2_reg;

        ax_reg <= NX_BITS'(n2_reg) * NX_BITS'(a1_reg);
        bx_reg <= NX_BITS'(n1_reg) * NX_BITS'(a2_reg);
        cy_reg <= NY_BITS'(s1_reg) * NY_BITS'(n2_reg);
        dy_reg <= NY_BITS'(s2_reg) * NY_BITS'(n1_reg);
        dd_reg <= DEN_BITS'(d_reg);

        numx_reg <= ax_reg - bx_reg;
        numy_reg <= cy_reg - dy_reg;
        denx_reg <= dd_reg <<< 2;
        deny_reg <= dd_reg;
    end

    assign done  = v_reg[4];
    assign num_x = numx_reg;
    assign num_y = numy_reg;
    assign den_x = denx_reg;
    assign den_y = deny_reg;

endmodule
`default_nettype wire

// ===== hdl/tcpp_div.sv =====
`default_nettype none
module tcpp_div import tcpp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [QW-1:0]       num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [QW-1:0]       quo
);

    logic                    busy_reg, done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [QW-1:0]           q_reg;
    logic [DEN_BITS-1:0]     den_reg, rem_reg;
    logic [DEN_BITS:0]       rem_sh, rem_sub;

    always_comb begin
        rem_sh  = {rem_reg, q_reg[QW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_reg <= rem_sub[DEN_BITS-1:0];
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DEN_BITS-1:0];
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
`default_nettype wire

// ===== hdl/tcpp_lane.sv =====
`default_nettype none
module tcpp_lane import tcpp_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [COORD_BITS-1:0]       px,
    input  logic [COORD_BITS-1:0]       py,
    input  logic signed [CEN_BITS-1:0]  cx,
    input  logic signed [CEN_BITS-1:0]  cy,
    output logic                        done,
    output lane_res_t                   res
);

    logic v1_reg, v2_reg, busy_reg, done_reg;
    logic [ROOT_CNT_BITS-1:0] cnt_reg;
    logic signed [DXC_BITS-1:0] dx_reg, dy_reg;
    logic [SQ_BITS-2:0]  sqx_reg, sqy_reg;
    logic [SQ_BITS-1:0]  sq_reg;
    logic [RAD_BITS-1:0] rad_reg;
    logic [LEN_BITS+1:0] rem_reg;
    logic [LEN_BITS-1:0] root_reg;

    logic signed [2*DXC_BITS-1:0] mx, my;
    logic [SQ_BITS-1:0]  sum;
    logic [LEN_BITS+1:0] rem_sh, trial;

    always_comb begin
        mx = (2*DXC_BITS)'(dx_reg) * (2*DXC_BITS)'(dx_reg);
        my = (2*DXC_BITS)'(dy_reg) * (2*DXC_BITS)'(dy_reg);
        sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        rem_sh = {rem_reg[LEN_BITS-1:0], rad_reg[RAD_BITS-1 -: 2]};
        trial  = {root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= 1'b0;
            if (v2_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ROOT_CNT_BITS'(LEN_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= DXC_BITS'(to_s(px)) - DXC_BITS'(cx);
        dy_reg  <= DXC_BITS'(to_s(py)) - DXC_BITS'(cy);
        sqx_reg <= mx[SQ_BITS-2:0];
        sqy_reg <= my[SQ_BITS-2:0];
        if (v2_reg) begin
            sq_reg   <= sum;
            rad_reg  <= RAD_BITS'({sum, {(2*LEN_FRAC){1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[RAD_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[LEN_BITS-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[LEN_BITS-2:0], 1'b0};
            end
        end
    end

    assign done    = done_reg;
    assign res.sq  = sq_reg;
    assign res.len = root_reg;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import tcpp_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD = 400;

    typedef struct {
        action_t act;
        logic [VAL_BITS-1:0] val_a;
        logic [VAL_BITS-1:0] val_b;
    } gesture_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [ACT_BITS-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [SIZE_BITS-1:0] cfg_data = '0;

    three_contact_pan_pinch_recognizer_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Model state of the recognizer.
    logic [SIZE_BITS-1:0] g_width, g_height, g_base_w, g_base_h;
    mode_t g_mode;
    logic [ID_BITS-1:0] g_ref_id;
    longint g_ref_x, g_ref_y, g_surf_x, g_surf_y, g_last_x, g_last_y, g_cx, g_cy;

    gesture_out_t pending_gestures[$];
    int errors = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int action_hits[5];
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clamp_div(longint num, longint den);
        longint lim, q;
        lim = longint'(CEN_LIM);
        if (den == 0) return num > 0 ? lim : (num < 0 ? -lim : 0);
        q = num / den;
        if (q > lim) return lim;
        if (q < -lim) return -lim;
        return q;
    endfunction

    function automatic longint unsigned centre_dist_sq(longint x, longint y);
        longint dx, dy;
        dx = x - g_cx;
        dy = y - g_cy;
        return longint'(dx * dx + dy * dy);
    endfunction

    function automatic longint unsigned radius_q(longint unsigned sq);
        return isqrt(sq << (2 * LEN_FRAC));
    endfunction

    function automatic logic [VAL_BITS-1:0] zoom_size(longint unsigned scale, bit sat,
                                                      logic [SIZE_BITS-1:0] base);
        longint unsigned v;
        if (base == 0) return '0;
        if (sat) return VAL_BITS'(65535);
        v = (scale * base) >> FRAC_BITS;
        return v > 65535 ? VAL_BITS'(65535) : VAL_BITS'(v);
    endfunction

    function automatic gesture_out_t recognize(in_frame_t f);
        gesture_out_t r;
        logic [ID_BITS-1:0] id[3];
        longint px[3], py[3];
        longint m12x, m12y, m23x, m23y, c1, c2, a1, a2, s1, s2, n1, n2, d, dx, dy, whole;
        longint unsigned sq[3], mx, ln, lr, scale;
        bit pinch, sat;
        r.act = ACT_NONE;
        r.val_a = '0;
        r.val_b = '0;
        id[0] = f.first_id;  px[0] = f.first_x;  py[0] = f.first_y;
        id[1] = f.second_id; px[1] = f.second_x; py[1] = f.second_y;
        id[2] = f.third_id;  px[2] = f.third_x;  py[2] = f.third_y;
        if (f.contact_count < MIN_CONTACTS) begin
            g_mode = MODE_IDLE;
            return r;
        end
        if (g_mode == MODE_IDLE) begin
            m12x = (px[0] + px[1]) / 2; m12y = (py[0] + py[1]) / 2;
            m23x = (px[2] + px[1]) / 2; m23y = (py[2] + py[1]) / 2;
            c1 = px[2] - m12x; c2 = px[0] - m23x;
            a1 = c1 != 0 ? 4 * c1 : 1;
            a2 = c2 != 0 ? 4 * c2 : 1;
            s1 = py[2] - m12y; s2 = py[0] - m23y;
            n1 = m12y * a1 - 4 * s1 * m12x;
            n2 = m23y * a2 - 4 * s2 * m23x;
            d = s1 * a2 - s2 * a1;
            g_ref_id = id[0];
            g_ref_x = px[0]; g_ref_y = py[0];
            g_surf_x = f.first_surface_x; g_surf_y = f.first_surface_y;
            g_last_x = 0; g_last_y = 0;
            g_cx = clamp_div(n2 * a1 - n1 * a2, 4 * d);
            g_cy = clamp_div(s1 * n2 - s2 * n1, d);
            for (int k = 0; k < 3; k++) sq[k] = centre_dist_sq(px[k], py[k]);
            mx = sq[0];
            if (sq[1] > mx) mx = sq[1];
            if (sq[2] > mx) mx = sq[2];
            pinch = 1'b1;
            for (int k = 0; k < 3; k++) if (!(4 * sq[k] > mx)) pinch = 1'b0;
            if (pinch) begin
                g_mode = MODE_PINCH;
                g_base_w = g_width;
                g_base_h = g_height;
                r.act = ACT_PINCH;
            end else begin
                g_mode = MODE_NAV;
                r.act = ACT_NAV;
            end
            return r;
        end
        for (int k = 0; k < 3; k++) begin
            if (id[k] != g_ref_id) continue;
            if (g_mode == MODE_NAV) begin
                dx = px[k] - g_ref_x;
                dy = py[k] - g_ref_y;
                if (dx != g_last_x || dy != g_last_y) begin
                    g_last_x = dx;
                    g_last_y = dy;
                    r.act = ACT_MOVE;
                    r.val_a = VAL_BITS'(g_surf_x - dx);
                    r.val_b = VAL_BITS'(g_surf_y - dy);
                    return r;
                end
            end else begin
                ln = radius_q(centre_dist_sq(px[k], py[k]));
                whole = longint'(ln >> LEN_FRAC);
                if (whole != g_last_x) begin
                    lr = radius_q(centre_dist_sq(g_ref_x, g_ref_y));
                    g_last_x = whole;
                    scale = 0;
                    sat = (ln == 0);
                    if (!sat) begin
                        scale = (lr << FRAC_BITS) / ln;
                        sat = scale >= (64'd1 << (17 + FRAC_BITS));
                    end
                    r.act = ACT_RESIZE;
                    r.val_a = zoom_size(scale, sat, g_base_w);
                    r.val_b = zoom_size(scale, sat, g_base_h);
                    return r;
                end
            end
        end
        return r;
    endfunction

    task automatic send_frame(in_frame_t f);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tdata = f;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_gestures.push_back(recognize(f));
        frames_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_WIDTH) g_width = val;
        else if (idx == REG_HEIGHT) g_height = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_gestures.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic set_portal(logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h);
        wait_drained();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    function automatic longint clip(longint v);
        return v < 0 ? 0 : (v > 4095 ? 4095 : v);
    endfunction

    function automatic in_frame_t touch(int cnt, logic [ID_BITS-1:0] i0, longint x0, longint y0,
                                        logic [ID_BITS-1:0] i1, longint x1, longint y1,
                                        logic [ID_BITS-1:0] i2, longint x2, longint y2);
        in_frame_t f;
        f = '0;
        f.contact_count = CNT_BITS'(cnt);
        f.first_id = i0;  f.first_x = COORD_BITS'(clip(x0));  f.first_y = COORD_BITS'(clip(y0));
        f.second_id = i1; f.second_x = COORD_BITS'(clip(x1)); f.second_y = COORD_BITS'(clip(y1));
        f.third_id = i2;  f.third_x = COORD_BITS'(clip(x2));  f.third_y = COORD_BITS'(clip(y2));
        f.first_surface_x = COORD_BITS'($urandom);
        f.first_surface_y = COORD_BITS'($urandom);
        return f;
    endfunction

    task automatic test_directed();
        in_frame_t f;
        set_portal(13'd1000, 13'd500);
        send_frame(touch(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        f = '1;
        f.contact_count = CNT_BITS'(2);
        send_frame(f);
        // Near-equilateral triangle around (2000, 2000) starts a pinch.
        send_frame(touch(3, 1, 2000, 1000, 2, 2866, 2500, 3, 1134, 2500));
        send_frame(touch(3, 1, 2000, 500, 2, 3300, 2750, 3, 700, 2750));
        send_frame(touch(4, 1, 2000, 500, 2, 3300, 2750, 3, 700, 2750));
        send_frame(touch(3, 2, 2000, 1500, 3, 2433, 2250, 1, 2000, 1600));
        send_frame(touch(3, 7, 2000, 1500, 8, 2433, 2250, 9, 1567, 2250));
        // The reference contact sits on the centre, so the radius is zero.
        send_frame(touch(3, 1, g_cx, g_cy, 2, 2433, 2250, 3, 1567, 2250));
        send_frame(touch(1, 1, 5, 5, 0, 0, 0, 0, 0, 0));
        send_frame(touch(3, 40, 100, 100, 41, 110, 100, 42, 3000, 3000));
        send_frame(touch(3, 40, 100, 100, 41, 110, 100, 42, 3000, 3000));
        send_frame(touch(3, 41, 110, 100, 42, 3000, 3000, 40, 4095, 0));
        send_frame(touch(3, 40, 0, 4095, 41, 110, 100, 42, 3000, 3000));
        send_frame(touch(2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Collinear contacts make the medians parallel.
        send_frame(touch(3, 5, 100, 100, 6, 200, 200, 7, 300, 300));
        send_frame(touch(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Third contact on the first median's midpoint x needs the nudge.
        send_frame(touch(3, 5, 100, 100, 6, 300, 100, 7, 200, 500));
        send_frame(touch(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // All contacts at the origin: every distance is zero.
        send_frame(touch(15, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_frame(touch(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_frame(touch(15, 16'hFFFF, 4095, 4095, 16'hFFFF, 4095, 4095, 16'hFFFF, 4095, 4095));
        send_frame(touch(15, 16'hFFFF, 4095, 4094, 16'hFFFF, 4095, 4095, 16'hFFFF, 0, 4095));
    endtask

    // One gesture: a starting frame, several follow-up frames, then a lift.
    task automatic random_gesture();
        logic [ID_BITS-1:0] ids[3];
        longint cx, cy, rad, ox[3], oy[3], num, den, mvx, mvy;
        int steps, cnt, rot;
        in_frame_t f;
        for (int k = 0; k < 3; k++) ids[k] = ID_BITS'($urandom);
        cx = $urandom_range(300, 3800);
        cy = $urandom_range(300, 3800);
        rad = $urandom_range(1, 1200);
        if ($urandom_range(0, 1) == 0) begin
            ox[0] = 0;              oy[0] = -rad;
            ox[1] = rad * 7 / 8;    oy[1] = rad / 2;
            ox[2] = -rad * 7 / 8;   oy[2] = rad / 2;
            for (int k = 0; k < 3; k++) begin
                ox[k] += $urandom_range(0, 40) - 20;
                oy[k] += $urandom_range(0, 40) - 20;
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                ox[k] = longint'($urandom_range(0, 4095)) - cx;
                oy[k] = longint'($urandom_range(0, 4095)) - cy;
            end
        end
        send_frame(touch($urandom_range(3, 15), ids[0], cx + ox[0], cy + oy[0],
                         ids[1], cx + ox[1], cy + oy[1], ids[2], cx + ox[2], cy + oy[2]));
        steps = $urandom_range(2, 12);
        num = 16;
        mvx = 0;
        mvy = 0;
        for (int s = 0; s < steps; s++) begin
            den = 16;
            if ($urandom_range(0, 2) != 0) num = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                mvx = longint'($urandom_range(0, 600)) - 300;
                mvy = longint'($urandom_range(0, 600)) - 300;
            end
            cnt = $urandom_range(3, 15);
            rot = $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) begin
                f = '0;
                f = in_frame_t'(IN_W'($urandom));
                f.third_y = COORD_BITS'($urandom);
                f.first_id = ID_BITS'($urandom);
                f.contact_count = CNT_BITS'(cnt);
                send_frame(f);
            end else begin
                send_frame(touch(cnt,
                    ids[rot], cx + mvx + ox[rot] * num / den, cy + mvy + oy[rot] * num / den,
                    ids[(rot+1)%3], cx + mvx + ox[(rot+1)%3] * num / den,
                    cy + mvy + oy[(rot+1)%3] * num / den,
                    ids[(rot+2)%3], cx + mvx + ox[(rot+2)%3] * num / den,
                    cy + mvy + oy[(rot+2)%3] * num / den));
            end
        end
        f = '0;
        f.contact_count = CNT_BITS'($urandom_range(0, 2));
        f.first_id = ID_BITS'($urandom);
        f.third_x = COORD_BITS'($urandom);
        send_frame(f);
    endtask

    task automatic test_random(int target);
        int stop_at;
        stop_at = frames_sent + target;
        while (frames_sent < stop_at) random_gesture();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random(60);
    endtask

    task automatic test_no_idling();
        gaps_on = 1'b0;
        test_random(350);
    endtask

    initial begin
        g_width = '0; g_height = '0; g_base_w = '0; g_base_h = '0;
        g_mode = MODE_IDLE;
        g_ref_id = '0;
        g_ref_x = 0; g_ref_y = 0; g_surf_x = 0; g_surf_y = 0;
        g_last_x = 0; g_last_y = 0; g_cx = 0; g_cy = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        set_portal(13'($urandom), 13'($urandom));
        test_random(450);
        set_portal(13'd8191, 13'd8191);
        test_backpressure();
        test_random(150);
        set_portal(13'd0, 13'd8191);
        test_random(150);
        set_portal(13'd8191, 13'd0);
        test_random(150);
        set_portal(13'($urandom), 13'($urandom));
        test_no_idling();
        wait_drained();
        $display("Covered %0d frames and %0d results; actions none/nav/pinch/move/resize:",
                 frames_sent, results_seen);
        $display("  %0d %0d %0d %0d %0d, under several portal sizes and back-pressure.",
                 action_hits[0], action_hits[1], action_hits[2], action_hits[3], action_hits[4]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        gesture_out_t exp_g;
        out_data_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (pending_gestures.size() == 0) begin
                $error("result with no frame waiting: action %0d", m_tuser);
                errors++;
            end else begin
                exp_g = pending_gestures.pop_front();
                if (int'(exp_g.act) < 5) action_hits[int'(exp_g.act)]++;
                if (m_tuser !== exp_g.act) begin
                    $error("action: expected %0d, got %0d", exp_g.act, m_tuser);
                    errors++;
                end
                if (got.value_a !== exp_g.val_a) begin
                    $error("value_a: expected %0d, got %0d",
                           $signed(exp_g.val_a), $signed(got.value_a));
                    errors++;
                end
                if (got.value_b !== exp_g.val_b) begin
                    $error("value_b: expected %0d, got %0d",
                           $signed(exp_g.val_b), $signed(got.value_b));
                    errors++;
                end
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || (pending_gestures.size() == 0 && !s_tvalid && !cfg_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== three_contact_pan_pinch_recognizer_top.f =====
hdl/tcpp_pkg.sv
hdl/tcpp_median.sv
hdl/tcpp_div.sv
hdl/tcpp_lane.sv
hdl/three_contact_pan_pinch_recognizer_top.sv
sim/tb.sv
